FILE: sv/mandelbrot_escape_time_macros.svh
// Assertion macros for the Mandelbrot escape-time block.
// Included by the top level; relies on clk and rst_n being in scope.
`ifndef MANDELBROT_ESCAPE_TIME_MACROS_SVH
`define MANDELBROT_ESCAPE_TIME_MACROS_SVH

`ifndef SYNTH
// Checked property, masked while reset is asserted.
`define MET_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mandelbrot_escape_time assertion failed");
// Checked property, evaluated during reset as well.
`define MET_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("mandelbrot_escape_time assertion failed");
`else
`define MET_ASSERT(lbl, prop)
`define MET_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

FILE: sv/met_pkg.sv
// Shared types, constants and helpers for the Mandelbrot escape-time block.
// No dependencies; imported by the controller, the datapath and the top level.
package met_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = DATA_WIDTH - 4;
  localparam int PROD_W     = 2 * DATA_WIDTH;
  localparam int SUM_W      = PROD_W + 1;
  localparam int EXT_W      = DATA_WIDTH + 4;
  localparam int ITER_W     = 16;

  localparam logic [ITER_W-1:0] MAX_ITER_RESET = 16'd256;

  // 4.0 at fraction 2*FRAC_BITS, the escape bound on |z|^2.
  localparam logic [SUM_W-1:0] ESCAPE_LIMIT =
    {{(SUM_W-1){1'b0}}, 1'b1} << (2 * FRAC_BITS + 2);

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] c_real;
    logic signed [DATA_WIDTH-1:0] c_imag;
  } in_word_t;

  typedef struct packed {
    logic        [ITER_W-1:0]     iteration_count;
    logic signed [DATA_WIDTH-1:0] final_real;
    logic signed [DATA_WIDTH-1:0] final_imag;
  } out_word_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_RR,
    ST_MUL_II,
    ST_MUL_RI,
    ST_EVAL,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    SEL_RR,
    SEL_II,
    SEL_RI
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    mul_sel_t mul_sel;
    logic     cap_sr;
    logic     cap_si;
    logic     update;
  } met_cmd_t;

  typedef struct packed {
    logic limit_hit;
    logic escaped;
  } met_sts_t;

  // Clamp a widened signed value to the signed DATA_WIDTH range.
  function automatic logic signed [DATA_WIDTH-1:0] sat_dw(
    input logic signed [EXT_W-1:0] x
  );
    logic [EXT_W-DATA_WIDTH:0] top;
    logic signed [DATA_WIDTH-1:0] res;
    top = x[EXT_W-1:DATA_WIDTH-1];
    if ((&top) || !(|top)) begin
      res = x[DATA_WIDTH-1:0];
    end else if (x[EXT_W-1]) begin
      res = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    end else begin
      res = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

FILE: sv/met_ctrl.sv
// Sequencer for the escape-time iteration: issues the three products per pass.
// Depends on met_pkg for the state, command and status types.
module met_ctrl
  import met_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  met_sts_t sts,
  output met_cmd_t cmd,
  output logic     busy,
  output logic     out_valid
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (start) state_nxt = ST_MUL_RR;
      ST_MUL_RR: state_nxt = sts.limit_hit ? ST_DONE : ST_MUL_II;
      ST_MUL_II: state_nxt = ST_MUL_RI;
      ST_MUL_RI: state_nxt = ST_EVAL;
      ST_EVAL:   state_nxt = sts.escaped ? ST_DONE : ST_MUL_RR;
      ST_DONE:   state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.mul_sel = SEL_RR;
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_MUL_RR: cmd.mul_sel = SEL_RR;
      ST_MUL_II: begin
        cmd.mul_sel = SEL_II;
        cmd.cap_sr  = 1'b1;
      end
      ST_MUL_RI: begin
        cmd.mul_sel = SEL_RI;
        cmd.cap_si  = 1'b1;
      end
      ST_EVAL:   cmd.update = !sts.escaped;
      ST_DONE:   out_valid = 1'b1;
      default:   busy = 1'b1;
    endcase
  end

endmodule

FILE: sv/met_datapath.sv
// Datapath for the escape-time iteration: one shared multiplier, z, c and count.
// Depends on met_pkg for widths, word types, command/status structs and sat_dw.
module met_datapath
  import met_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [ITER_W-1:0] cfg_wdata,
  input  in_word_t          in_word,
  input  met_cmd_t          cmd,
  output met_sts_t          sts,
  output out_word_t         result
);

  logic        [ITER_W-1:0]     max_iter_r;
  logic signed [DATA_WIDTH-1:0] cr_r, ci_r, zr_r, zi_r;
  logic        [ITER_W-1:0]     n_r;
  logic signed [PROD_W-1:0]     p_r;
  logic        [PROD_W-1:0]     sr_r, si_r;

  logic signed [DATA_WIDTH-1:0] op_a, op_b;
  logic signed [PROD_W-1:0]     prod;
  logic        [SUM_W-1:0]      mag_sum;
  logic signed [SUM_W-1:0]      diff, diff_sh, twop, twop_sh;
  logic signed [EXT_W-1:0]      nr, ni, sum_r, sum_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r <= MAX_ITER_RESET;
    end else if (cfg_we) begin
      max_iter_r <= cfg_wdata;
    end
  end

  always_comb begin
    case (cmd.mul_sel)
      SEL_II: begin
        op_a = zi_r;
        op_b = zi_r;
      end
      SEL_RI: begin
        op_a = zr_r;
        op_b = zi_r;
      end
      default: begin
        op_a = zr_r;
        op_b = zr_r;
      end
    endcase
  end

  assign prod = op_a * op_b;

  // Squares are non-negative, so their sum is taken unsigned with one carry bit.
  assign mag_sum = {1'b0, sr_r} + {1'b0, si_r};
  assign diff    = $signed({1'b0, sr_r}) - $signed({1'b0, si_r});
  assign diff_sh = diff >>> FRAC_BITS;
  assign twop    = {p_r, 1'b0};
  assign twop_sh = twop >>> FRAC_BITS;

  // Both parts lie within +/-4.0 whenever the update is taken.
  assign nr    = diff_sh[EXT_W-1:0];
  assign ni    = twop_sh[EXT_W-1:0];
  assign sum_r = nr + EXT_W'(cr_r);
  assign sum_i = ni + EXT_W'(ci_r);

  always_ff @(posedge clk) begin
    p_r <= prod;
    if (cmd.cap_sr) sr_r <= p_r;
    if (cmd.cap_si) si_r <= p_r;
    if (cmd.load) begin
      cr_r <= in_word.c_real;
      ci_r <= in_word.c_imag;
      zr_r <= '0;
      zi_r <= '0;
      n_r  <= '0;
    end else if (cmd.update) begin
      zr_r <= sat_dw(sum_r);
      zi_r <= sat_dw(sum_i);
      n_r  <= n_r + 1'b1;
    end
  end

  assign sts.limit_hit = (n_r == max_iter_r);
  assign sts.escaped   = (mag_sum > ESCAPE_LIMIT);

  assign result.iteration_count = n_r;
  assign result.final_real      = zr_r;
  assign result.final_imag      = zi_r;

endmodule

FILE: sv/mandelbrot_escape_time.sv
// A point ends when its pass count reaches the limit or when z escapes in a pass.
// Throughput: one point at a time; each pass walks the single shared multiplier
// through re^2, im^2 and re*im in turn, then a test step.
// Reset (synchronous, rst_n low) returns to idle and sets max_iterations to 256.
// The result word is shown for one cycle on out_valid; the receiver cannot stall.
module mandelbrot_escape_time
  import met_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [ITER_W-1:0] cfg_wdata,
  input  logic              start,
  input  in_word_t          in_word,
  output logic              busy,
  output logic              out_valid,
  output out_word_t         out_word
);

  `include "mandelbrot_escape_time_macros.svh"

  // The controller walks each pass through its multiply states for re^2, im^2 and
  // re*im and then its evaluate state; the datapath holds z, c, the pass count and the limit.
  met_cmd_t cmd;
  met_sts_t sts;

  met_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // The pass count, final z and limit register live here. The result word is
  // read straight from the z and count registers, which hold still while the
  // controller sits in its done state.
  met_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .result    (out_word)
  );

  // The result strobe lasts a single cycle.
  `MET_ASSERT(a_strobe_single, out_valid |=> !out_valid)
  // A result is only presented while a point is still being held.
  `MET_ASSERT(a_strobe_busy, out_valid |-> busy)
  // An accepted word always makes the block busy on the next cycle.
  `MET_ASSERT(a_accept_busy, (start && !busy) |=> (busy && !out_valid))
  // Reset leaves the block idle with no result pending.
  `MET_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> (!busy && !out_valid))

endmodule

FILE: sim/tb_top.sv
// Self-checking testbench for mandelbrot_escape_time: directed and random points c,
// with each result compared against an in-bench escape-time predictor.
// Depends on met_pkg (word types and widths) and the mandelbrot_escape_time top level.
module tb_top;
  import met_pkg::*;

  // Fixed-point helpers at the block's Q4.F format.
  localparam int ONE_Q = 1 << FRAC_BITS;
  localparam logic signed [DATA_WIDTH-1:0] MAX_Q = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] MIN_Q = {1'b1, {(DATA_WIDTH-1){1'b0}}};

  // Documented reset value of max_iterations, checked before any write.
  localparam logic [ITER_W-1:0] DEFAULT_LIMIT = 16'd256;
  localparam logic [ITER_W-1:0] FULL_LIMIT    = 16'hFFFF;

  // The predictor works on signed values wide enough for exact squares and sums.
  localparam int WW = 2 * DATA_WIDTH + 4;
  typedef logic signed [WW-1:0] wide_t;

  // Cycles allowed after the last result, and an overall run limit that covers one
  // point at the full limit plus every random point at its slowest limit.
  localparam int TAIL_CYCLES  = 16;
  localparam int CYCLE_LIMIT  = 8_000_000;
  localparam int POINTS_PER_SETTING = 40;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [ITER_W-1:0] cfg_wdata;
  logic       start;
  in_word_t   in_word;
  logic       busy;
  logic       out_valid;
  out_word_t  out_word;

  // Predicted result words, oldest first, and the predictor's copy of the register.
  out_word_t         expected_results[$];
  out_word_t         want_word;
  logic [ITER_W-1:0] limit_copy;
  int                mismatch_count;
  int                cycle_count;

  mandelbrot_escape_time u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .start     (start),
    .in_word   (in_word),
    .busy      (busy),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: a hung block or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Escape-time predictor. Each pass tests |z|^2 <= 4 exactly on the wide squares,
  // counts the pass, then forms z*z + c. The products are brought back to F fraction
  // bits by an arithmetic shift, which rounds toward minus infinity, and each part is
  // clamped to the signed word range. A limit of zero runs no pass at all.
  function automatic out_word_t predict_escape(in_word_t w, logic [ITER_W-1:0] limit);
    wide_t             cr, ci, zr, zi, ar, ai, sr, si, nr, ni, prod;
    wide_t             two, four, zmax, zmin;
    logic [ITER_W-1:0] n;
    int unsigned       pass;
    logic              running;
    out_word_t         r;
    cr   = {{(WW-DATA_WIDTH){w.c_real[DATA_WIDTH-1]}}, w.c_real};
    ci   = {{(WW-DATA_WIDTH){w.c_imag[DATA_WIDTH-1]}}, w.c_imag};
    two  = 1;
    two  = two << (FRAC_BITS + 1);
    four = 1;
    four = four << (2 * FRAC_BITS + 2);
    zmax = 1;
    zmax = (zmax << (DATA_WIDTH - 1)) - 1;
    zmin = -zmax - 1;
    zr   = 0;
    zi   = 0;
    n    = '0;
    pass = 0;
    running = 1'b1;
    while (running && pass < limit) begin
      ar = (zr < 0) ? -zr : zr;
      ai = (zi < 0) ? -zi : zi;
      sr = ar * ar;
      si = ai * ai;
      // A part beyond 2.0 has escaped already; the wide test covers the rest.
      if (ar > two || ai > two || (sr + si) > four) begin
        running = 1'b0;
      end else begin
        n    = n + 1'b1;
        nr   = (sr - si) >>> FRAC_BITS;
        prod = ar * ai * 2;
        ni   = (((zr < 0) != (zi < 0)) ? -prod : prod) >>> FRAC_BITS;
        nr   = nr + cr;
        ni   = ni + ci;
        if (nr > zmax) nr = zmax;
        else if (nr < zmin) nr = zmin;
        if (ni > zmax) ni = zmax;
        else if (ni < zmin) ni = zmin;
        zr   = nr;
        zi   = ni;
        pass = pass + 1;
      end
    end
    r.iteration_count = n;
    r.final_real      = zr[DATA_WIDTH-1:0];
    r.final_imag      = zi[DATA_WIDTH-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch in %s: got %0h, expected %0h", what, got, want);
    mismatch_count++;
  endtask

  // Result checker. out_valid and out_word are sampled at the rising edge that ends
  // the strobe cycle, before the block updates them, so no ordering race exists.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result word with nothing pending",
                        64'(out_word.iteration_count), '0);
      end else begin
        want_word = expected_results.pop_front();
        if (out_word.iteration_count !== want_word.iteration_count)
          report_mismatch("iteration_count", 64'(out_word.iteration_count),
                          64'(want_word.iteration_count));
        if (out_word.final_real !== want_word.final_real)
          report_mismatch("final_real", 64'(out_word.final_real),
                          64'(want_word.final_real));
        if (out_word.final_imag !== want_word.final_imag)
          report_mismatch("final_imag", 64'(out_word.final_imag),
                          64'(want_word.final_imag));
      end
    end
  end

  function automatic in_word_t point(input logic signed [DATA_WIDTH-1:0] re,
                                     input logic signed [DATA_WIDTH-1:0] im);
    in_word_t w;
    w.c_real = re;
    w.c_imag = im;
    return w;
  endfunction

  // One of the corner values of a coordinate: zero, +-2.0, +-1 LSB, the extremes.
  function automatic logic signed [DATA_WIDTH-1:0] pick_special();
    logic signed [DATA_WIDTH-1:0] v;
    case ($urandom_range(0, 6))
      0:       v = '0;
      1:       v = 2 * ONE_Q;
      2:       v = -2 * ONE_Q;
      3:       v = 1;
      4:       v = -1;
      5:       v = MAX_Q;
      default: v = MIN_Q;
    endcase
    return v;
  endfunction

  // Most points fall in the box around the set, where orbits run long and the
  // rounding of negative products matters; the rest are wide box, raw bits and corners.
  function automatic in_word_t random_point();
    int unsigned sel;
    in_word_t    w;
    sel = $urandom_range(0, 9);
    if (sel < 6) begin
      w.c_real = int'($urandom_range(0, 5 * ONE_Q / 2)) - 2 * ONE_Q;
      w.c_imag = int'($urandom_range(0, 5 * ONE_Q / 2)) - 5 * ONE_Q / 4;
    end else if (sel < 8) begin
      w.c_real = int'($urandom_range(0, 4 * ONE_Q)) - 2 * ONE_Q;
      w.c_imag = int'($urandom_range(0, 4 * ONE_Q)) - 2 * ONE_Q;
    end else if (sel == 8) begin
      w = {$urandom, $urandom};
    end else begin
      w.c_real = pick_special();
      w.c_imag = pick_special();
    end
    return w;
  endfunction

  // Offer one word. start is redrawn at every falling edge, low with the given odds,
  // so idle cycles land anywhere, including the cycles where busy drops. busy is
  // stable at the falling edge, so start && !busy here means the next rising edge
  // accepts the word. The task returns at the falling edge after the accept and
  // leaves start as it was, so a following word can keep it high without a glitch.
  task automatic send_point(input in_word_t w, input int idle_pct);
    logic offer;
    in_word <= w;
    forever begin
      offer = ($urandom_range(0, 99) >= idle_pct);
      start <= offer;
      if (offer && !busy) break;
      @(negedge clk);
    end
    expected_results.push_back(predict_escape(w, limit_copy));
    @(negedge clk);
  endtask

  // Hold off until every predicted word has come back and the block is idle.
  task automatic wait_drained();
    start <= 1'b0;
    @(negedge clk);
    while (expected_results.size() != 0 || busy) @(negedge clk);
  endtask

  // The register is only written while the block is idle.
  task automatic set_max_iterations(input logic [ITER_W-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    limit_copy = value;
  endtask

  // Directed points at the reset limit: the origin, the exact boundary values of
  // plus and minus 2.0 (where |z|^2 equals 4 and the pass still counts), the word
  // extremes that escape after one pass, tiny values and a few known orbits.
  task automatic test_reset_limit();
    send_point(point(0, 0), 0);
    send_point(point(-2 * ONE_Q, 0), 0);
    send_point(point(2 * ONE_Q, 0), 0);
    send_point(point(0, 2 * ONE_Q), 0);
    send_point(point(0, -2 * ONE_Q), 0);
    send_point(point(2 * ONE_Q + 1, 0), 0);
    send_point(point(MAX_Q, MAX_Q), 0);
    send_point(point(MIN_Q, MIN_Q), 0);
    send_point(point(MAX_Q, MIN_Q), 0);
    send_point(point(MIN_Q, MAX_Q), 0);
    send_point(point(1, -1), 0);
    send_point(point(ONE_Q / 4, 0), 0);
    send_point(point(0, ONE_Q), 0);
    send_point(point(-ONE_Q, 0), 0);
    send_point(point(-ONE_Q / 10, ONE_Q / 20 * 13), 0);
    send_point(point(-ONE_Q * 3 / 4, ONE_Q / 10), 0);
  endtask

  // A zero limit runs no pass: count 0 and z = 0 whatever c is.
  task automatic test_zero_limit();
    set_max_iterations('0);
    send_point(point(0, 0), 0);
    send_point(point(MAX_Q, MIN_Q), 0);
    send_point(random_point(), 0);
  endtask

  task automatic test_single_pass();
    set_max_iterations(16'd1);
    send_point(point(0, 0), 0);
    send_point(point(MIN_Q, MAX_Q), 0);
    send_point(random_point(), 0);
  endtask

  // The full limit: the origin runs every pass and drives the count to all ones.
  task automatic test_full_limit();
    set_max_iterations(FULL_LIMIT);
    send_point(point(0, 0), 0);
    send_point(point(2 * ONE_Q, 0), 0);
    send_point(point(MIN_Q, 0), 0);
  endtask

  // Random points in groups, each group under a freshly drawn limit. The write at
  // each group boundary makes the sender wait until every result is back.
  task automatic test_random_points(input int idle_pct, input int count);
    logic [ITER_W-1:0] limit;
    int sent;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: limit = DEFAULT_LIMIT;
        4, 5:       limit = ITER_W'($urandom_range(1, 8));
        6, 7:       limit = ITER_W'($urandom_range(9, 64));
        8:          limit = ITER_W'($urandom_range(65, 600));
        default:    limit = ITER_W'($urandom_range(0, 2));
      endcase
      set_max_iterations(limit);
      repeat (POINTS_PER_SETTING) begin
        if (sent < count) begin
          // Now and then a longer gap, so a fresh word also lands well after idle.
          if (idle_pct != 0 && $urandom_range(0, 19) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 40)) @(negedge clk);
          end
          send_point(random_point(), idle_pct);
          sent++;
        end
      end
    end
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    start          = 1'b0;
    in_word        = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    limit_copy     = DEFAULT_LIMIT;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_limit();
    test_zero_limit();
    test_single_pass();
    test_full_limit();
    test_random_points(11, 300);
    test_random_points(51, 250);
    test_random_points(0, 250);

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
